// ===== rtl/hcs_pkg.sv =====
// Package for the Hamiltonian cycle search unit: sizes, item types, queue entry.
// No dependencies.
package hcs_pkg;
	localparam int NV = 8;
	localparam int VW = 3;
	localparam int DW = 4;

	typedef struct packed {
		logic [2:0] row_index;
		logic [7:0] row_bits;
		logic       is_last_row;
	} in_item_t;

	typedef struct packed {
		logic       found;
		logic [2:0] vertex;
		logic       is_last;
	} out_item_t;

	// queue entry from front to back
	typedef struct packed {
		logic          wr_en;
		logic [VW-1:0] idx;
		logic [NV-1:0] bits;
		logic          go;
	} cmd_t;
endpackage

// ===== rtl/hamiltonian_cycle_search_unit.sv =====
// Top level of the Hamiltonian cycle search unit.
// Depends on hcs_pkg, hcs_front, hcs_queue, hcs_back.
//
// Usage: present a row item on din with start high; it is taken at a rising
// edge where start is high and busy is low. Rows go into a two-entry queue
// and are stored by the back end one per cycle while it is idle. A row
// with is_last_row set launches a depth-first search from vertex 0; the
// search tests one candidate vertex per cycle against the stored
// adjacency row of the previous path vertex. Each path position tries
// candidates up to 7 and then backtracks, and each full path gets a
// closing edge check; a dense graph with no edge back to vertex 0 walks
// all 5040 orderings. Rows sent during a search wait in the queue; busy
// rises only when the queue is full.
// Results: done strobes for one cycle per result item on result. A found
// cycle gives NV+1 items on consecutive cycles (path then vertex 0, last
// marked); a miss gives one item with found=0. The receiver cannot stall.
// Reset (arst_n low) clears the queue, search state and path; the
// adjacency rows are not cleared and must be written before use.
module hamiltonian_cycle_search_unit import hcs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  in_item_t  din,
	output logic      busy,
	output logic      done,
	output out_item_t result
);
	logic full, empty, push, pop;
	cmd_t wcmd, rcmd;

	hcs_front u_front (.start, .din, .full, .busy, .push, .cmd(wcmd));
	hcs_queue u_queue (.clk, .arst_n, .push, .wdata(wcmd), .pop, .full, .empty,
		.rdata(rcmd));
	hcs_back u_back (.clk, .arst_n, .empty, .cmd(rcmd), .pop, .done, .result);
endmodule

// ===== rtl/hcs_front.sv =====
// Front part: accepts row items and classifies them into queue commands.
// Depends on hcs_pkg.
module hcs_front import hcs_pkg::*; (
	input  logic     start,
	input  in_item_t din,
	input  logic     full,
	output logic     busy,
	output logic     push,
	output cmd_t     cmd
);
	assign busy = full;
	assign push = start && !full;
	always_comb begin
		cmd.wr_en = ({1'b0, din.row_index} < (VW+1)'(NV));
		cmd.idx   = din.row_index;
		cmd.bits  = din.row_bits;
		cmd.go    = din.is_last_row;
	end
endmodule

// ===== rtl/hcs_queue.sv =====
// Two-entry command queue between front and back.
// Depends on hcs_pkg.
module hcs_queue import hcs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wdata,
	input  logic pop,
	output logic full,
	output logic empty,
	output cmd_t rdata
);
	cmd_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign rdata = mem_q[rp_q];
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

// ===== rtl/hcs_back.sv =====
// Back part: stores rows, runs the backtracking search one candidate a cycle,
// emits results. Depends on hcs_pkg.
module hcs_back import hcs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      empty,
	input  cmd_t      cmd,
	output logic      pop,
	output logic      done,
	output out_item_t result
);
	typedef enum logic [4:0] {
		S_IDLE = 5'b00001, S_TRY = 5'b00010, S_CLOSE = 5'b00100,
		S_EMIT = 5'b01000, S_FAIL = 5'b10000
	} state_t;

	state_t         st_q;
	logic [NV-1:0]  adj_q [NV];
	logic [VW-1:0]  path_q [NV];
	logic [NV-1:0]  used_q;
	logic [DW-1:0]  pos_q;
	logic [VW:0]    cand_q;
	logic [DW-1:0]  oi_q;
	logic [NV-1:0]  prow;
	logic [VW-1:0]  cv, lastv;
	logic           ok;

	assign pop   = (st_q == S_IDLE) && !empty;
	assign prow  = adj_q[path_q[pos_q[VW-1:0] - VW'(1)]];
	assign cv    = cand_q[VW-1:0];
	assign ok    = prow[cv] && !used_q[cv];
	assign lastv = path_q[NV-1];

	always_ff @(posedge clk) begin
		if (pop && cmd.wr_en) adj_q[cmd.idx] <= cmd.bits;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE; used_q <= '0; pos_q <= '0; cand_q <= '0; oi_q <= '0;
			done <= 1'b0; result <= '0;
			for (int i = 0; i < NV; i++) path_q[i] <= '0;
		end else begin
			done <= 1'b0;
			case (st_q)
				S_IDLE: if (pop && cmd.go) begin
					path_q[0] <= '0; used_q <= NV'(1);
					pos_q <= DW'(1); cand_q <= (VW+1)'(1); st_q <= S_TRY;
				end
				S_TRY: begin
					if (cand_q < (VW+1)'(NV)) begin
						if (ok) begin
							path_q[pos_q[VW-1:0]] <= cv;
							used_q[cv] <= 1'b1;
							cand_q <= (VW+1)'(1);
							pos_q <= pos_q + DW'(1);
							if (pos_q == DW'(NV-1)) st_q <= S_CLOSE;
						end else cand_q <= cand_q + (VW+1)'(1);
					end else if (pos_q <= DW'(1)) begin
						st_q <= S_FAIL;
					end else begin
						// backtrack one level
						used_q[path_q[pos_q[VW-1:0] - VW'(1)]] <= 1'b0;
						cand_q <= {1'b0, path_q[pos_q[VW-1:0] - VW'(1)]} + (VW+1)'(1);
						pos_q <= pos_q - DW'(1);
					end
				end
				S_CLOSE: begin
					if (adj_q[lastv][0]) begin
						oi_q <= '0; st_q <= S_EMIT;
					end else begin
						used_q[lastv] <= 1'b0;
						cand_q <= {1'b0, lastv} + (VW+1)'(1);
						pos_q <= DW'(NV-1);
						st_q <= S_TRY;
					end
				end
				S_EMIT: begin
					done <= 1'b1;
					result.found <= 1'b1;
					result.vertex <= (oi_q == DW'(NV)) ? 3'(0) : 3'(path_q[oi_q[VW-1:0]]);
					result.is_last <= (oi_q == DW'(NV));
					oi_q <= oi_q + DW'(1);
					if (oi_q == DW'(NV)) st_q <= S_IDLE;
				end
				S_FAIL: begin
					done <= 1'b1; result <= '{found: 1'b0, vertex: 3'd0, is_last: 1'b1};
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// Testbench for hamiltonian_cycle_search_unit: streams adjacency rows, predicts
// each cycle search in place and checks every emitted vertex. Needs hcs_pkg.
module tb;
	import hcs_pkg::*;

	localparam int WATCHDOG_LIMIT = 400000;
	localparam int RANDOM_ITEMS   = 310;

	logic      clk;
	logic      arst_n;
	logic      start;
	in_item_t  din;
	logic      busy;
	logic      done;
	out_item_t result;

	logic [NV-1:0] adj_rows [NV];   // local copy of the stored matrix
	out_item_t     cycle_q[$];      // vertices still owed by the block
	int            mismatches;
	int            items_sent;
	int            searches;
	int            cycles_found;
	int            quiet_cycles;
	bit            idle_on;

	hamiltonian_cycle_search_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.din    (din),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// depth-first search from vertex 0, candidates in ascending order
	function automatic void predict_cycle();
		logic [2:0] path [NV];
		logic [NV-1:0] used;
		int depth, first, pos, cand, prev;
		bit hit, ok;
		out_item_t r;
		for (int i = 0; i < NV; i++) path[i] = '0;
		used  = 1;
		depth = 1;
		first = 1;
		hit   = 0;
		forever begin
			pos = depth;
			if (pos >= NV) begin
				if (adj_rows[path[NV-1]][0]) begin
					hit = 1;
					break;
				end
				pos = NV - 1;
				used[path[pos]] = 1'b0;
				first = path[pos] + 1;
				depth = pos;
				continue;
			end
			prev = path[pos-1];
			ok = 0;
			for (cand = first; cand < NV; cand++) begin
				path[pos] = cand[2:0];
				if (adj_rows[prev][cand] && !used[cand]) begin
					ok = 1;
					break;
				end
			end
			if (ok) begin
				used[cand] = 1'b1;
				depth = pos + 1;
				first = 1;
			end else begin
				path[pos] = '0;
				if (pos <= 1) break;
				pos--;
				used[path[pos]] = 1'b0;
				first = path[pos] + 1;
				depth = pos;
			end
		end
		searches++;
		if (hit) begin
			cycles_found++;
			for (int i = 0; i <= NV; i++) begin
				r.found   = 1'b1;
				r.vertex  = path[i % NV];
				r.is_last = (i == NV);
				cycle_q.push_back(r);
			end
		end else begin
			r = '{found: 1'b0, vertex: 3'd0, is_last: 1'b1};
			cycle_q.push_back(r);
		end
	endfunction

	// one row item; start stays high until the next idle or send
	task automatic send_row(input logic [2:0] idx, input logic [7:0] bits, input bit last);
		@(negedge clk);
		start <= 1'b1;
		din   <= '{row_index: idx, row_bits: bits, is_last_row: last};
		do @(posedge clk); while (busy);
		adj_rows[idx] = bits;
		items_sent++;
		if (last) predict_cycle();
		if (idle_on && $urandom_range(0, 3) == 0) idle_cycles(int'($urandom_range(1, 6)));
	endtask

	task automatic idle_cycles(input int n);
		@(negedge clk);
		start <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic drain();
		while (cycle_q.size() != 0) @(posedge clk);
	endtask

	// complete graph, no exit from 0, complete again, ring, and a dense miss (no edge back to 0)
	task automatic test_directed_graphs();
		for (int i = 0; i < NV; i++) send_row(3'(i), 8'hFF, i == NV - 1);
		send_row(3'd0, 8'h00, 1'b1);
		send_row(3'd0, 8'hFF, 1'b1);
		for (int i = 0; i < NV; i++)
			send_row(3'(i), 8'(1 << ((i + 1) % NV)), i == NV - 1);
		for (int i = 1; i < NV; i++) send_row(3'(i), 8'hFE, i == NV - 1);
	endtask

	// mostly well-formed batches ending in a search, some loose rows
	task automatic test_random_searches(input int budget);
		int k;
		logic [7:0] bits;
		while (budget > 0) begin
			if ($urandom_range(0, 4) == 0) begin
				send_row(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
					$urandom_range(0, 3) == 0);
				budget--;
			end else begin
				k = int'($urandom_range(1, NV));
				for (int j = 0; j < k; j++) begin
					bits = 8'($urandom_range(0, 255) | $urandom_range(0, 255));
					if ($urandom_range(0, 2) == 0) bits |= 8'($urandom_range(0, 255));
					send_row(3'($urandom_range(0, 7)), bits, j == k - 1);
				end
				budget -= k;
			end
		end
	endtask

	// sender holds off until the block has emitted everything
	task automatic test_hold_until_empty();
		send_row(3'd3, 8'hFF, 1'b1);
		idle_cycles(1);
		drain();
		send_row(3'd5, 8'h5A, 1'b1);
	endtask

	// back to back, no gaps
	task automatic test_tail_no_idle();
		idle_on = 0;
		for (int i = 0; i < 24; i++)
			send_row(3'($urandom_range(0, 7)),
				8'($urandom_range(0, 255) | $urandom_range(0, 255)), i % 3 == 2);
	endtask

	// result checker
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && done) begin
			if (cycle_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result found=%0d vertex=%0d last=%0d",
						result.found, result.vertex, result.is_last);
			end else begin
				want = cycle_q.pop_front();
				if (result !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp f=%0d v=%0d l=%0d got f=%0d v=%0d l=%0d",
							want.found, want.vertex, want.is_last,
							result.found, result.vertex, result.is_last);
				end
			end
		end
	end

	// watchdog: cycles with neither an accept nor a result
	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		din          = '0;
		mismatches   = 0;
		items_sent   = 0;
		searches     = 0;
		cycles_found = 0;
		quiet_cycles = 0;
		idle_on      = 1;
		for (int i = 0; i < NV; i++) adj_rows[i] = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_graphs();
		test_hold_until_empty();
		test_random_searches(RANDOM_ITEMS);
		test_tail_no_idle();
		idle_cycles(1);
		drain();
		repeat (50) @(posedge clk);
		if (cycle_q.size() != 0) begin
			mismatches++;
			$display("%0d results never arrived", cycle_q.size());
		end

		$display("sent %0d rows, ran %0d searches, %0d found a cycle",
			items_sent, searches, cycles_found);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

// ===== hamiltonian_cycle_search_unit.f =====
rtl/hcs_pkg.sv
rtl/hcs_front.sv
rtl/hcs_queue.sv
rtl/hcs_back.sv
rtl/hamiltonian_cycle_search_unit.sv
sim/tb.sv
